FILE: hdl/map_grid_line_generator_defines.svh
// Assertion macros for the map grid line generator.
`ifndef MAP_GRID_LINE_GENERATOR_DEFINES_SVH
`define MAP_GRID_LINE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MGLG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mglg: same-cycle check failed");

// Next-cycle implication.
`define MGLG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mglg: next-cycle check failed");

`endif

FILE: hdl/mglg_pkg.sv
// Shared types and constants of the map grid line generator.
`timescale 1ns / 1ps
`default_nettype none
package mglg_pkg;

  localparam int NSLOTS  = 20;
  localparam int EPS_Q30 = 10737;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GO   = 1'b1;

  localparam logic REG_MIN_GRID = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_PLEN, S_SEARCH, S_RANGE, S_COUNT, S_START,
    S_LINE, S_CLAMP, S_DIV, S_RD_A, S_RD_B, S_MUL, S_ACC, S_OUT, S_NOLINE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [33:0] mag;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/mglg_ifs.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface mglg_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [4:0]         slot;
  logic signed [31:0] value;
  modport source(output valid, command, slot, value, input ready);
  modport sink(input valid, command, slot, value, output ready);
endinterface

interface mglg_out_if;
  logic               valid;
  logic               ready;
  logic               line_axis;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic               no_lines;
  logic               truncated;
  logic               last;
  modport source(output valid, line_axis, start_x, start_y, start_z, end_x, end_y,
                 end_z, no_lines, truncated, last, input ready);
  modport sink(input valid, line_axis, start_x, start_y, start_z, end_x, end_y,
               end_z, no_lines, truncated, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/mglg_div.sv
// Radix-2 restoring divider: quotient of mag * 2^30 by den, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mglg_div import mglg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [32:0] rem;
  logic [31:0] low;
  logic [5:0]  cnt;
  logic        done;
  logic [33:0] trial;
  logic        ge;

  assign trial = {rem, low[31]};
  assign ge    = trial >= {2'b00, req.den};

  // den is held by the caller for the whole run
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // mag <= 2*den, so mag/4 < den: the top part never overflows
        rem <= {1'b0, req.mag[33:2]};
        low <= {req.mag[1:0], 30'b0};
        cnt <= 6'd32;
      end else if (cnt != 6'd0) begin
        rem  <= ge ? 33'(trial - {2'b00, req.den}) : trial[32:0];
        low  <= {low[30:0], ge};
        cnt  <= cnt - 6'd1;
        done <= (cnt == 6'd1);
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = low;

endmodule
`default_nettype wire

FILE: hdl/map_grid_line_generator.sv
// Top level of the map grid line generator.
// Usage:
//  - cmd (sink) takes requests. A load request (command 0) writes value into
//    region slot 0..19; slots above 19 are dropped. A go request
//    (command 1) plans both axes and emits grid line segments on line.
//  - line (source) carries one segment per result, vertical lines first,
//    last set on the final result of a go. A go with no lines gives one
//    result with no_lines set.
//  - APB port: register 0 (byte address 0) is the minimum grid spacing, Q8.24.
//  - Sequence: a load is a single write. A go fetches the snapshot, then per
//    axis either skips an empty span or plans a step; after a start step,
//    each line takes setup, the serial divider, six coordinates (two corner
//    reads, multiply, add), and a step into the result register.
//  - cmd.ready is high only between go requests; one request at a time.
//  - The result register lets the next line compute while a result waits;
//    when line.ready stays low the block stalls before loading the next one.
//  - Reset (rst, synchronous) clears the valid bits of the region store so
//    every slot reads as zero, drops any pending result and returns the
//    minimum grid spacing register to 1/16.
`timescale 1ns / 1ps
`default_nettype none
`include "map_grid_line_generator_defines.svh"
module map_grid_line_generator import mglg_pkg::*; #(
  parameter int MAX_LINES      = 32,
  parameter int MAX_STEP_SHIFT = 28
) (
  input  logic        clk,
  input  logic        rst,
  mglg_in_if.sink     cmd,
  mglg_out_if.source  line,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int          CW   = $clog2(MAX_LINES + 1);
  localparam logic [4:0]  SMAX = 5'(MAX_STEP_SHIFT);
  localparam logic [CW-1:0] LMAX = CW'(MAX_LINES);

  state_t state, state_next;

  // config
  logic [31:0] mgd;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_GRID) ? mgd : 32'd0;

  // region store: one write port (loads), one registered read port
  logic [31:0] mem [NSLOTS];
  logic [NSLOTS-1:0] vld;
  logic [31:0] rd_data;
  logic        rd_vld;
  logic [4:0]  raddr;
  logic signed [31:0] rvalue;
  logic        in_fire, we;

  assign cmd.ready = (state == S_IDLE);
  assign in_fire   = cmd.valid && cmd.ready;
  assign we        = in_fire && (cmd.command == CMD_LOAD) && (cmd.slot < 5'(NSLOTS));
  assign rvalue    = rd_vld ? rd_data : 32'd0;

  always_ff @(posedge clk) begin
    if (we) mem[cmd.slot] <= cmd.value;
    rd_data <= mem[raddr];
  end

  // working registers
  logic signed [31:0] snap [8];
  logic [3:0]         fidx;
  logic               ax;
  logic [63:0]        p;
  logic [4:0]         s;
  logic               esel;
  logic signed [33:0] left_r, right_r;
  logic signed [33:0] first_x, first_y;
  logic [CW-1:0]      cnt_x, cnt_y, li;
  logic [4:0]         sh_x, sh_y;
  logic               trunc;
  logic signed [63:0] num_r;
  logic               neg;
  logic signed [32:0] k;
  logic signed [31:0] fval;
  logic signed [65:0] prod;
  logic [2:0]         cidx;
  logic signed [31:0] coord [6];

  // result register
  logic               out_valid;
  logic               o_axis, o_no_lines, o_trunc, o_last;
  logic signed [31:0] o_c [6];
  logic               out_free;
  assign out_free = !out_valid || line.ready;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mglg_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // per-axis views of the snapshot: x uses edges 01/23, y uses 12/30
  logic signed [31:0] w0, w1, ea, eb, plen;
  logic signed [32:0] wlen;
  logic [63:0]        pl_sh;
  logic               fine;
  logic signed [33:0] first_cur;
  logic [CW-1:0]      cnt_cur;
  logic [4:0]         s_cur;
  logic               line_end;

  assign w0   = ax ? snap[1] : snap[0];
  assign w1   = ax ? snap[3] : snap[2];
  assign ea   = ax ? snap[5] : snap[4];
  assign eb   = ax ? snap[7] : snap[6];
  assign plen = esel ? eb : ea;
  assign wlen = {w1[31], w1} - {w0[31], w0};
  // step still too coarse while plen*2^30 / 2^(s+1) >= p
  assign pl_sh = {2'b00, plen, 30'b0} >> (s + 5'd1);
  assign fine  = plen[31] || (pl_sh < p);

  assign first_cur = ax ? first_y : first_x;
  assign cnt_cur   = ax ? cnt_y : cnt_x;
  assign s_cur     = ax ? sh_y : sh_x;
  assign line_end  = (li + CW'(1)) == cnt_cur;

  // line range in Q.30
  logic signed [33:0] b0, b1;
  logic signed [63:0] u0, u1;
  assign b0 = {w0[31], w0[31], w0} + 34'sd536870912;
  assign b1 = {w1[31], w1[31], w1} + 34'sd536870912;
  assign u0 = (64'(b0) <<< s) + 64'sd1073741824 - 64'(EPS_Q30);
  assign u1 = (64'(b1) <<< s) + 64'(EPS_Q30);

  logic signed [34:0] diff;
  assign diff = 35'(right_r) - 35'(left_r);

  // line position and numerator
  logic signed [34:0] idx;
  logic signed [63:0] xv;
  assign idx = 35'(first_cur) + 35'(li);
  assign xv  = (64'(idx) <<< (5'd30 - s_cur)) - 64'sd536870912 - 64'(w0);

  logic signed [63:0] den64, nd, d2, numc;
  assign den64 = 64'(wlen);
  assign nd    = -den64;
  assign d2    = den64 <<< 1;
  assign numc  = (num_r < nd) ? nd : ((num_r > d2) ? d2 : num_r);

  assign div_req.start = (state == S_CLAMP);
  assign div_req.mag   = numc[63] ? 34'(-numc) : 34'(numc);
  assign div_req.den   = wlen[31:0];

  // corner addressing: coordinate j of corner c is at slot 8 + 3c + j
  logic [1:0] c_from, c_to, cj;
  logic [4:0] a_from, a_to;
  always_comb begin
    if (cidx < 3'd3) begin
      c_from = 2'd0;
      c_to   = ax ? 2'd3 : 2'd1;
      cj     = cidx[1:0];
    end else begin
      c_from = ax ? 2'd1 : 2'd3;
      c_to   = 2'd2;
      cj     = 2'(cidx - 3'd3);
    end
  end
  assign a_from = 5'd8 + 5'(c_from) * 5'd3 + 5'(cj);
  assign a_to   = 5'd8 + 5'(c_to) * 5'd3 + 5'(cj);

  // lerp arithmetic
  logic signed [32:0] dd;
  logic signed [65:0] pr;
  logic signed [35:0] pr_sh;
  logic signed [36:0] rs;
  logic signed [31:0] rs_sat;
  assign dd    = {rvalue[31], rvalue} - {fval[31], fval};
  assign pr    = prod + 66'sd536870912;
  assign pr_sh = pr[65:30];
  assign rs    = 37'(pr_sh) + 37'(fval);
  assign rs_sat = (rs > 37'sd2147483647) ? 32'sh7fffffff :
                  (rs < -37'sd2147483648) ? 32'sh80000000 : rs[31:0];

  // next state and read address
  always_comb begin
    state_next = state;
    raddr      = 5'd0;
    case (state)
      S_IDLE:   if (in_fire && cmd.command == CMD_GO) state_next = S_FETCH;
      S_FETCH: begin
        raddr = 5'(fidx[2:0]);
        if (fidx == 4'd8) state_next = S_PLEN;
      end
      S_PLEN: begin
        if (wlen[32] || wlen == 33'sd0) state_next = ax ? S_START : S_PLEN;
        else state_next = S_SEARCH;
      end
      S_SEARCH: if (s == SMAX || (fine && esel)) state_next = S_RANGE;
      S_RANGE:  state_next = S_COUNT;
      S_COUNT:  state_next = ax ? S_START : S_PLEN;
      S_START: begin
        if (cnt_x == '0 && cnt_y == '0) state_next = S_NOLINE;
        else state_next = S_LINE;
      end
      S_LINE:   state_next = S_CLAMP;
      S_CLAMP:  state_next = S_DIV;
      S_DIV:    if (div_rsp.done) state_next = S_RD_A;
      S_RD_A: begin
        raddr      = a_from;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        raddr      = a_to;
        state_next = S_MUL;
      end
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = (cidx == 3'd5) ? S_OUT : S_RD_A;
      S_OUT: begin
        if (out_free) begin
          if (line_end && (ax || cnt_y == '0)) state_next = S_IDLE;
          else state_next = S_LINE;
        end
      end
      S_NOLINE: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // control registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      mgd       <= 32'd1048576;
      vld       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      cidx      <= 3'd0;
      fidx      <= 4'd0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_MIN_GRID) mgd <= pwdata;
      if (we) vld[cmd.slot] <= 1'b1;
      rd_vld <= vld[raddr];
      if ((state == S_OUT || state == S_NOLINE) && out_free) out_valid <= 1'b1;
      else if (line.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:  fidx <= 4'd0;
        S_FETCH: fidx <= fidx + 4'd1;
        S_LINE:  cidx <= 3'd0;
        S_ACC:   if (cidx != 3'd5) cidx <= cidx + 3'd1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ax    <= 1'b0;
        trunc <= 1'b0;
      end
      S_FETCH: if (fidx != 4'd0) snap[3'(fidx - 4'd1)] <= rvalue;
      S_PLEN: begin
        p    <= mgd * wlen[31:0];
        s    <= 5'd2;
        esel <= 1'b0;
        if (wlen[32] || wlen == 33'sd0) begin
          if (ax) cnt_y <= '0;
          else cnt_x <= '0;
          ax <= 1'b1;
        end
      end
      S_SEARCH: begin
        if (s != SMAX) begin
          if (fine) esel <= 1'b1;
          else s <= s + 5'd1;
        end
      end
      S_RANGE: begin
        left_r  <= u0[63:30];
        right_r <= u1[63:30];
      end
      S_COUNT: begin
        if (ax) begin
          first_y <= left_r;
          sh_y    <= s;
        end else begin
          first_x <= left_r;
          sh_x    <= s;
        end
        if (diff < 35'sd0) begin
          if (ax) cnt_y <= '0;
          else cnt_x <= '0;
        end else if (diff >= 35'(MAX_LINES)) begin
          if (ax) cnt_y <= LMAX;
          else cnt_x <= LMAX;
          trunc <= 1'b1;
        end else begin
          if (ax) cnt_y <= CW'(diff + 35'sd1);
          else cnt_x <= CW'(diff + 35'sd1);
        end
        ax <= 1'b1;
      end
      S_START: begin
        ax <= (cnt_x == '0);
        li <= '0;
      end
      S_LINE:  num_r <= xv;
      S_CLAMP: neg <= numc[63];
      S_DIV:   if (div_rsp.done) k <= neg ? -$signed({1'b0, div_rsp.quot})
                                          : $signed({1'b0, div_rsp.quot});
      S_RD_B:  fval <= rvalue;
      S_MUL:   prod <= dd * k;
      S_ACC:   coord[cidx] <= rs_sat;
      S_OUT: begin
        if (out_free) begin
          o_axis     <= ax;
          for (int n = 0; n < 6; n++) o_c[n] <= coord[n];
          o_no_lines <= 1'b0;
          o_trunc    <= trunc;
          o_last     <= line_end && (ax || cnt_y == '0);
          if (line_end) begin
            ax <= 1'b1;
            li <= '0;
          end else begin
            li <= li + CW'(1);
          end
        end
      end
      S_NOLINE: begin
        if (out_free) begin
          o_axis     <= 1'b0;
          for (int n = 0; n < 6; n++) o_c[n] <= 32'sd0;
          o_no_lines <= 1'b1;
          o_trunc    <= 1'b0;
          o_last     <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign line.valid     = out_valid;
  assign line.line_axis = o_axis;
  assign line.start_x   = o_c[0];
  assign line.start_y   = o_c[1];
  assign line.start_z   = o_c[2];
  assign line.end_x     = o_c[3];
  assign line.end_y     = o_c[4];
  assign line.end_z     = o_c[5];
  assign line.no_lines  = o_no_lines;
  assign line.truncated = o_trunc;
  assign line.last      = o_last;

  `MGLG_ASSERT_NOW(a_noline_last, line.valid && line.no_lines, line.last)
  `MGLG_ASSERT_NEXT(a_go_busy, in_fire && cmd.command == CMD_GO, !cmd.ready)
  `MGLG_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state == S_DIV)
  `MGLG_ASSERT_NOW(a_cidx_range, state == S_ACC, cidx <= 3'd5)

endmodule
`default_nettype wire
